>>> rtl/core/sqr_pkg.sv
// Package for the shifting queue with reverse: command and status codes,
// field widths and the default queue depth. No dependencies.
package sqr_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;

	typedef enum logic [2:0] {
		CMD_ENQ  = 3'd0,
		CMD_DEQ  = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_DUMP = 3'd3,
		CMD_REV  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

>>> rtl/core/shifting_queue_with_reverse.sv
// Top level of the shifting queue with reverse.
// Depends on sqr_pkg and sqr_ram.
//
// Usage: a word (cmd, push_value) is taken at a rising edge with start high
// and busy low. Results appear on status/out_value/last for exactly one cycle,
// flagged by strobe, the first one in the cycle after the word is taken;
// the receiver cannot stall them. Enqueue, dequeue, peek and reverse give
// one result each and keep busy low, so one word per cycle is sustained.
// Dump gives one result per held entry, one per cycle, and holds busy high
// until the read of the final entry has been issued; on an empty queue it
// gives a single empty result. Unused codes give no result. Entries sit in
// one RAM as a ring buffer with a head pointer and a direction flag;
// reverse moves the head to the back and flips the direction, dequeue
// steps the head. Every read goes through the single registered RAM read
// port, which sets the one-entry-per-cycle dump rate. Reset clears occupancy,
// head, direction and all control; entry contents are left as they are.
module shifting_queue_with_reverse
	import sqr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              cmd,
	input  logic signed [VAL_W-1:0] push_value,
	output logic                    strobe,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);
	localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

	typedef enum logic {S_IDLE, S_DUMP} state_t;

	state_t          state_q;
	logic [OW-1:0]   occ_q;
	logic [PW-1:0]   head_q;
	logic            dir_q;
	logic [PW-1:0]   cnt_q;
	logic            strobe_q;
	logic [1:0]      status_q;
	logic [VAL_W-1:0] val_q;
	logic            last_q;
	logic            sel_ram_q;

	logic            accept;
	logic            we;
	logic [PW-1:0]   waddr;
	logic [PW-1:0]   raddr;
	logic [VAL_W-1:0] rdata;
	logic [PW-1:0]   occ_p;
	logic [PW-1:0]   occ_m1;

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] h,
			input logic [PW-1:0] off, input logic d);
		logic [PW:0] s;
		if (!d) begin
			s = {1'b0, h} + {1'b0, off};
			if (s >= DEPTH_W)
				s = s - DEPTH_W;
		end else begin
			s = {1'b0, h} - {1'b0, off};
			if (h < off)
				s = s + DEPTH_W;
		end
		return s[PW-1:0];
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign occ_p  = occ_q[PW-1:0];
	assign occ_m1 = occ_q[PW-1:0] - PW'(1);

	assign raddr = phys(head_q, (state_q == S_DUMP) ? cnt_q : '0, dir_q);
	assign waddr = phys(head_q, occ_p, dir_q);
	assign we    = accept && (cmd == CMD_ENQ) && (occ_q != DEPTH_O);

	sqr_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(push_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			head_q    <= '0;
			dir_q     <= 1'b0;
			cnt_q     <= '0;
			strobe_q  <= 1'b0;
			status_q  <= ST_OK;
			val_q     <= '0;
			last_q    <= 1'b0;
			sel_ram_q <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			sel_ram_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						strobe_q <= 1'b1;
						status_q <= ST_OK;
						val_q    <= '0;
						last_q   <= 1'b1;
						case (cmd)
							CMD_ENQ: begin
								if (occ_q == DEPTH_O) begin
									status_q <= ST_FULL;
								end else begin
									val_q <= push_value;
									occ_q <= occ_q + OW'(1);
								end
							end
							CMD_DEQ, CMD_PEEK: begin
								if (occ_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									sel_ram_q <= 1'b1;
									if (cmd == CMD_DEQ) begin
										head_q <= phys(head_q, PW'(1), dir_q);
										occ_q  <= occ_q - OW'(1);
									end
								end
							end
							CMD_DUMP: begin
								if (occ_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									sel_ram_q <= 1'b1;
									if (occ_q != OW'(1)) begin
										last_q  <= 1'b0;
										cnt_q   <= PW'(1);
										state_q <= S_DUMP;
									end
								end
							end
							CMD_REV: begin
								if (occ_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									head_q <= phys(head_q, occ_m1, dir_q);
									dir_q  <= !dir_q;
								end
							end
							default: strobe_q <= 1'b0;
						endcase
					end
				end
				S_DUMP: begin
					strobe_q  <= 1'b1;
					sel_ram_q <= 1'b1;
					status_q  <= ST_OK;
					last_q    <= (cnt_q == occ_m1);
					cnt_q     <= cnt_q + PW'(1);
					if (cnt_q == occ_m1)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign last      = last_q;
	assign out_value = sel_ram_q ? rdata : val_q;

endmodule

>>> rtl/core/sqr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sqr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/sqr_chk.sv
// Port-level checker for the shifting queue with reverse, bound to the top.
// Depends on sqr_pkg.
module sqr_chk
	import sqr_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [2:0]       cmd,
	input logic             strobe,
	input logic [1:0]       status,
	input logic             last
);

	// busy only ever follows a dump word
	a_busy_dump: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && ($past(cmd) == CMD_DUMP))
		else $error("busy raised without a dump");

	// a non-final result belongs to a dump still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result outside a dump");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_OK) |-> last)
		else $error("error result not final");

	a_st_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY))
		else $error("bad status code");

	a_word_res: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((cmd == CMD_ENQ) || (cmd == CMD_DEQ) || (cmd == CMD_PEEK)
			|| (cmd == CMD_DUMP) || (cmd == CMD_REV)) |=> strobe)
		else $error("word gave no result");

endmodule

bind shifting_queue_with_reverse sqr_chk u_sqr_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.strobe(strobe),
	.status(status),
	.last  (last)
);

>>> sim/tb.sv
// Testbench for shifting_queue_with_reverse: directed and random command words, checked
// against a queue model held here. Depends on sqr_pkg and the RTL of the queue.
`timescale 1ns / 100ps

module tb;
	import sqr_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_WORDS = 90;
	localparam int QUIET_TAIL   = 30;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]              op;
		logic signed [VAL_W-1:0] val;
	} word_t;

	typedef struct packed {
		status_t                 st;
		logic signed [VAL_W-1:0] val;
		logic                    lst;
	} result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [2:0]              cmd = CMD_ENQ;
	logic signed [VAL_W-1:0] push_value = '0;
	logic                    strobe;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] out_value;
	logic                    last;

	word_t                   pending[$];
	result_t                 due_results[$];
	logic signed [VAL_W-1:0] held_vals[$];
	int                      gen_occ = 0;
	int                      errors = 0;
	int                      cycles = 0;
	int                      idle_left = 0;
	logic                    word_taken = 1'b0;

	shifting_queue_with_reverse #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.push_value(push_value),
		.strobe    (strobe),
		.status    (status),
		.out_value (out_value),
		.last      (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= REPORT_MAX) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// Expected results for one accepted word; updates the model queue.
	task automatic predict_results(input word_t w);
		logic signed [VAL_W-1:0] tmp;
		int lo;
		int hi;
		case (w.op)
			CMD_ENQ: begin
				if (held_vals.size() >= DEPTH) begin
					due_results.push_back(result_t'{ST_FULL, '0, 1'b1});
				end else begin
					held_vals.push_back(w.val);
					due_results.push_back(result_t'{ST_OK, w.val, 1'b1});
				end
			end
			CMD_DEQ: begin
				if (held_vals.size() == 0) begin
					due_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
				end else begin
					tmp = held_vals.pop_front();
					due_results.push_back(result_t'{ST_OK, tmp, 1'b1});
				end
			end
			CMD_PEEK: begin
				if (held_vals.size() == 0) begin
					due_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
				end else begin
					due_results.push_back(result_t'{ST_OK, held_vals[0], 1'b1});
				end
			end
			CMD_DUMP: begin
				if (held_vals.size() == 0) begin
					due_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
				end else begin
					for (int i = 0; i < held_vals.size(); i++) begin
						due_results.push_back(result_t'{ST_OK, held_vals[i],
							i == held_vals.size() - 1});
					end
				end
			end
			CMD_REV: begin
				if (held_vals.size() == 0) begin
					due_results.push_back(result_t'{ST_EMPTY, '0, 1'b1});
				end else begin
					lo = 0;
					hi = held_vals.size() - 1;
					while (lo < hi) begin
						tmp = held_vals[lo];
						held_vals[lo] = held_vals[hi];
						held_vals[hi] = tmp;
						lo++;
						hi--;
					end
					due_results.push_back(result_t'{ST_OK, '0, 1'b1});
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_word(input logic [2:0] op, input logic signed [VAL_W-1:0] v);
		pending.push_back(word_t'{op, v});
		if (op == CMD_ENQ && gen_occ < DEPTH) begin
			gen_occ++;
		end else if (op == CMD_DEQ && gen_occ > 0) begin
			gen_occ--;
		end
	endtask

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		word_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				idle_left <= $urandom_range(0, 15);
				start <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				cmd <= nxt.op;
				push_value <= nxt.val;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t exp;
		word_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected word: status %0d value %0d last %0d",
						status, out_value, last));
				end else begin
					exp = due_results.pop_front();
					if (status !== exp.st || out_value !== exp.val || last !== exp.lst) begin
						flag_mismatch($sformatf(
							"status %0d/%0d value %0d/%0d last %0d/%0d (expected/actual)",
							exp.st, status, exp.val, out_value, exp.lst, last));
					end
				end
			end
			if (start && !busy) begin
				predict_results(word_t'{cmd, push_value});
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int n;
		int r;
		int phase_left;
		bit filling;
		logic [2:0] op;

		// empty queue cases, extremes, unused codes, then fill to full, enqueue once more and dump
		add_word(CMD_PEEK, rand_value());
		add_word(CMD_DEQ, rand_value());
		add_word(CMD_DUMP, rand_value());
		add_word(CMD_REV, rand_value());
		add_word(CMD_ENQ, 32'h7FFF_FFFF);
		add_word(CMD_ENQ, 32'h8000_0000);
		add_word(CMD_ENQ, '1);
		add_word(CMD_ENQ, '0);
		add_word(CMD_PEEK, '0);
		add_word(CMD_REV, '1);
		add_word(CMD_DEQ, '0);
		add_word(CMD_SPARE_LO, rand_value());
		add_word(CMD_SPARE_HI, rand_value());
		while (gen_occ < DEPTH) begin
			add_word(CMD_ENQ, $urandom);
		end
		add_word(CMD_ENQ, rand_value());
		add_word(CMD_DUMP, '0);

		n = 0;
		phase_left = 0;
		filling = 1'b0;
		while (n < RANDOM_WORDS) begin
			if (phase_left == 0) begin
				filling = 1'($urandom_range(0, 1));
				phase_left = $urandom_range(10, 30);
			end
			r = $urandom_range(0, 99);
			if (r < 4) begin
				add_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand_value());
			end else begin
				if (filling ? r < 60 : r < 25) begin
					op = CMD_ENQ;
				end else if (filling ? r < 68 : r < 60) begin
					op = CMD_DEQ;
				end else if (r < 75) begin
					op = CMD_PEEK;
				end else if (r < 88) begin
					op = CMD_DUMP;
				end else begin
					op = CMD_REV;
				end
				add_word(op, rand_value());
				n++;
				phase_left--;
			end
		end

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (pending.size() != 0 || start || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sqr_pkg.sv
rtl/core/sqr_ram.sv
rtl/core/shifting_queue_with_reverse.sv
rtl/core/sqr_chk.sv
sim/tb.sv
